### sv/ptfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptfd_pkg
// Shared types and constants of the parent table failure detector.
// ----------------------------------------------------------------------------
`default_nettype none
package ptfd_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] KIND_HEARD   = 2'd0;
  localparam logic [1:0] KIND_CONFIRM = 2'd1;
  localparam logic [1:0] KIND_SELECT  = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [2:0] REG_OWN_LAYER   = 3'd0;
  localparam logic [2:0] REG_ALPHA       = 3'd1;
  localparam logic [2:0] REG_FACTOR      = 3'd2;
  localparam logic [2:0] REG_TIMEOUT     = 3'd3;
  localparam logic [2:0] REG_DETECT_EN   = 3'd4;
  localparam logic [2:0] REG_USE_EWMA    = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] now_us;
    logic [15:0] src_id;
    logic [7:0]  sender_layer;
    logic [15:0] voltage_mv;
    logic [31:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] chosen_id;
    logic [7:0]  parent_layer;
    logic [15:0] parent_voltage_mv;
    logic [6:0]  num_alive;
    logic        table_full;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] ident;
    logic [7:0]  layer;
    logic [15:0] voltage;
    logic        suspect;
    logic [47:0] last;
    logic [31:0] avg;
    logic        started;
  } entry_t;

endpackage
`default_nettype wire

### sv/ptfd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptfd_cell
// One table slot of the circulating ring; passes its entry on each shift.
// ----------------------------------------------------------------------------
`default_nettype none
module ptfd_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire ptfd_pkg::entry_t entry_i,
  output ptfd_pkg::entry_t     entry_o
);
  import ptfd_pkg::*;

  logic   valid_q;
  entry_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= entry_i;
    end
  end

  always_comb begin
    entry_o       = data_q;
    entry_o.valid = valid_q;
  end

endmodule
`default_nettype wire

### sv/ptfd_remu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptfd_remu
// Bit-serial restoring remainder of a 32-bit word by the alive count.
// ----------------------------------------------------------------------------
`default_nettype none
module ptfd_remu (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [31:0]                dividend_i,
  input  wire logic [ptfd_pkg::CNT_W-1:0] divisor_i,
  output logic                            done_o,
  output logic [ptfd_pkg::CNT_W-1:0]      rem_o
);
  import ptfd_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [31:0]      dvd_q, dvd_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [CNT_W:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[31]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[30:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = CNT_W'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[CNT_W-1:0];
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

### sv/parent_table_failure_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parent_table_failure_detector
// Parent table kept in a ring of slot cells with an EWMA heartbeat detector.
// ----------------------------------------------------------------------------
// Sequence: known-sender heard does a ring lap, the EWMA multiply and sum,
//   a second lap; confirm or insert two laps; select a lap, the divider and
//   a second lap. Layer mismatch or kind 3 goes straight to the result; a
//   miss, full table or empty select ends after one lap. One transaction at
//   a time, the next accepted once the result registers (waits on out stall).
// Reset: all slots invalid, registers at their documented reset values.
`default_nettype none
module parent_table_failure_detector (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire ptfd_pkg::in_item_t    in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output ptfd_pkg::out_item_t        out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [2:0]            cfg_index_i,
  input  wire logic [31:0]           cfg_data_i
);
  import ptfd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN1 = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SCAN2 = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  // configuration
  logic [7:0]  own_layer_q;
  logic [8:0]  alpha_q;
  logic [7:0]  factor_q;
  logic [31:0] timeout_q;
  logic        detect_en_q, use_ewma_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_layer_q <= 8'd1;
      alpha_q     <= 9'd64;
      factor_q    <= 8'd48;
      timeout_q   <= 32'd60000000;
      detect_en_q <= 1'b1;
      use_ewma_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_OWN_LAYER: own_layer_q <= cfg_data_i[7:0];
        REG_ALPHA:     alpha_q     <= cfg_data_i[8:0];
        REG_FACTOR:    factor_q    <= cfg_data_i[7:0];
        REG_TIMEOUT:   timeout_q   <= cfg_data_i;
        REG_DETECT_EN: detect_en_q <= cfg_data_i[0];
        REG_USE_EWMA:  use_ewma_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ring of slot cells
  entry_t ring [TABLE_DEPTH];
  entry_t head, tail;
  logic   shift_en;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == TABLE_DEPTH - 1) begin : g_tail
      ptfd_cell u_cell (.clk_i, .rst_ni, .shift_i(shift_en), .entry_i(tail),
                        .entry_o(ring[g]));
    end else begin : g_mid
      ptfd_cell u_cell (.clk_i, .rst_ni, .shift_i(shift_en), .entry_i(ring[g+1]),
                        .entry_o(ring[g]));
    end
  end
  assign head = ring[0];

  // control state
  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  in_item_t         item_q, item_d;
  out_item_t        res_q, res_d;
  logic             match_q, match_d, free_q, free_d;
  logic [IDX_W-1:0] mslot_q, mslot_d, fslot_q, fslot_d;
  logic [47:0]      mlast_q, mlast_d;
  logic [31:0]      mavg_q, mavg_d;
  logic             mstart_q, mstart_d;
  logic [CNT_W-1:0] count_q, count_d, seen_q, seen_d;
  logic [40:0]      p1_q, p2_q;
  logic [31:0]      s_q, newavg_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  // arithmetic
  logic [47:0] sil_head, sil_m;
  logic        bad;
  logic [8:0]  a_sat;
  logic [31:0] s_sat;
  logic [41:0] vsum;
  logic [33:0] vsh;
  logic        div_start, div_done;
  logic [CNT_W-1:0] pick;

  assign sil_head = item_q.now_us - head.last;
  assign sil_m    = item_q.now_us - mlast_q;
  assign a_sat    = (alpha_q > 9'd256) ? 9'd256 : alpha_q;
  assign s_sat    = (sil_m[47:32] != 16'd0) ? 32'hFFFF_FFFF : sil_m[31:0];
  assign vsum     = {1'b0, p1_q} + {1'b0, p2_q} + 42'd128;
  assign vsh      = vsum[41:8];

  always_comb begin
    if (use_ewma_q) begin
      bad = head.started &&
            ({sil_head, 4'b0} > {12'd0, 40'(factor_q) * 40'(head.avg)});
    end else begin
      bad = sil_head > {16'd0, timeout_q};
    end
  end

  ptfd_remu u_remu (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i (item_q.random_value),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .rem_o      (pick)
  );

  always_ff @(posedge clk_i) begin
    p1_q <= 41'(a_sat) * 41'(s_sat);
    p2_q <= 41'(9'd256 - a_sat) * 41'(mavg_q);
    s_q  <= s_sat;
    if (state_q == S_SUM) begin
      if (!mstart_q) newavg_q <= s_q;
      else if (vsh[33:32] != 2'd0) newavg_q <= 32'hFFFF_FFFF;
      else newavg_q <= vsh[31:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    item_d      = item_q;
    res_d       = res_q;
    match_d     = match_q;
    free_d      = free_q;
    mslot_d     = mslot_q;
    fslot_d     = fslot_q;
    mlast_d     = mlast_q;
    mavg_d      = mavg_q;
    mstart_d    = mstart_q;
    count_d     = count_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    tail        = head;
    shift_en    = 1'b0;
    div_start   = 1'b0;
    in_ready_o  = (state_q == S_IDLE);

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d    = in_data_i;
          res_d     = '0;
          res_d.chosen_id = 16'hFFFF;
          match_d   = 1'b0;
          free_d    = 1'b0;
          count_d   = '0;
          seen_d    = '0;
          idx_d     = '0;
          if (in_data_i.kind == KIND_CONFIRM || in_data_i.kind == KIND_SELECT ||
              (in_data_i.kind == KIND_HEARD &&
               ({1'b0, in_data_i.sender_layer} + 9'd1) == {1'b0, own_layer_q})) begin
            state_d = S_SCAN1;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN1: begin
        shift_en = 1'b1;
        idx_d    = idx_q + 1'b1;
        if (item_q.kind == KIND_SELECT) begin
          if (head.valid && !head.suspect) begin
            if (detect_en_q && bad) tail.suspect = 1'b1;
            else count_d = count_q + 1'b1;
          end
        end else begin
          if (head.valid && head.ident == item_q.src_id) begin
            match_d  = 1'b1;
            mslot_d  = idx_q;
            mlast_d  = head.last;
            mavg_d   = head.avg;
            mstart_d = head.started;
          end
          if (!head.valid && !free_q) begin
            free_d  = 1'b1;
            fslot_d = idx_q;
          end
        end
        if (idx_q == IDX_LAST) begin
          idx_d = '0;
          if (item_q.kind == KIND_SELECT) begin
            res_d.num_alive = 7'(count_d);
            if (count_d != '0) state_d = S_DIV;
            else state_d = S_DONE;
          end else if (match_d) begin
            state_d = (item_q.kind == KIND_HEARD) ? S_MUL : S_SCAN2;
          end else if (item_q.kind == KIND_HEARD && free_d) begin
            state_d = S_SCAN2;
          end else begin
            res_d.table_full = (item_q.kind == KIND_HEARD);
            state_d = S_DONE;
          end
          if (item_q.kind == KIND_SELECT && count_d != '0) div_start = 1'b1;
        end
      end
      S_MUL: state_d = S_SUM;
      S_SUM: state_d = S_SCAN2;
      S_DIV: begin
        if (div_done) state_d = S_SCAN2;
      end
      S_SCAN2: begin
        shift_en = 1'b1;
        idx_d    = idx_q + 1'b1;
        if (item_q.kind == KIND_SELECT) begin
          if (head.valid && !head.suspect) begin
            if (seen_q == pick && !res_q.found) begin
              res_d.found             = 1'b1;
              res_d.chosen_id         = head.ident;
              res_d.parent_layer      = head.layer;
              res_d.parent_voltage_mv = head.voltage;
            end
            seen_d = seen_q + 1'b1;
          end
        end else if (idx_q == (match_q ? mslot_q : fslot_q)) begin
          res_d.found  = 1'b1;
          tail.suspect = 1'b0;
          tail.last    = item_q.now_us;
          if (item_q.kind == KIND_CONFIRM) begin
            tail.avg     = '0;
            tail.started = 1'b0;
          end else if (match_q) begin
            tail.voltage = item_q.voltage_mv;
            tail.avg     = newavg_q;
            tail.started = 1'b1;
          end else begin
            tail.valid   = 1'b1;
            tail.ident   = item_q.src_id;
            tail.layer   = item_q.sender_layer;
            tail.voltage = item_q.voltage_mv;
            tail.avg     = '0;
            tail.started = 1'b0;
          end
        end
        if (idx_q == IDX_LAST) begin
          idx_d   = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      match_q     <= match_d;
      free_q      <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    res_q    <= res_d;
    mslot_q  <= mslot_d;
    fslot_q  <= fslot_d;
    mlast_q  <= mlast_d;
    mavg_q   <= mavg_d;
    mstart_q <= mstart_d;
    count_q  <= count_d;
    seen_q   <= seen_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
